// ----- rtl/scp_pkg.sv -----
`timescale 1ns / 1ps
package scp_pkg;

    localparam int POS_W      = 24;
    localparam int VEC_W      = 18;
    localparam int DIFF_W     = 25;
    localparam int PROD_W     = 43;
    localparam int TN_W       = 44;
    localparam int S_W        = 45;
    localparam int SMAG_W     = 44;
    localparam int YMAG_W     = 43;
    localparam int DETP_W     = 36;
    localparam int DET_W      = 37;
    localparam int DMAG_W     = 36;
    localparam int COL_W      = 12;
    localparam int SWID_W     = 12;
    localparam int HALF_W     = 11;
    localparam int TW_W       = 13;
    localparam int CEN_W      = 42;
    localparam int CEN_SH     = 40;
    localparam int CTR_W      = 16;
    localparam int ROW_W      = 12;
    localparam int CFG_W      = 24;
    localparam int FIFO_DEPTH = 4;

    typedef enum logic [2:0] {
        REG_EYE_X,
        REG_EYE_Y,
        REG_VIEW_DIR_X,
        REG_VIEW_DIR_Y,
        REG_PLANE_X,
        REG_PLANE_Y,
        REG_SCREEN_WIDTH,
        REG_TEXTURE_WIDTH
    } t_reg_idx;

    typedef struct packed {
        logic [POS_W-1:0]  eye_x;
        logic [POS_W-1:0]  eye_y;
        logic [VEC_W-1:0]  dir_x;
        logic [VEC_W-1:0]  dir_y;
        logic [VEC_W-1:0]  plane_x;
        logic [VEC_W-1:0]  plane_y;
        logic [SWID_W-1:0] screen_width;
        logic [TW_W-1:0]   texture_width;
    } t_cfg;

    typedef struct packed {
        logic [SMAG_W-1:0] s_mag;
        logic              neg;
        logic [YMAG_W-1:0] yn_mag;
        logic [DMAG_W-1:0] det_mag;
        logic [POS_W-1:0]  dep;
        logic [COL_W-1:0]  col;
        logic              fault;
    } t_item;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic             neg;
        logic             fault;
    } t_tag_a;

    typedef struct packed {
        logic [CTR_W-1:0] centre;
        logic [ROW_W-1:0] top;
        logic [ROW_W-1:0] bot;
        logic             fault;
        logic             neg;
    } t_tag_b;

endpackage

// ----- rtl/scp_fifo.sv -----
`timescale 1ns / 1ps
module scp_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  scp_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output scp_pkg::t_item o_item,
    output logic           o_empty
);
    import scp_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    t_item            r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [PTR_W:0]   r_cnt, n_cnt;

    always_comb begin
        n_wr  = i_push ? r_wr + 1'b1 : r_wr;
        n_rd  = i_pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + {{PTR_W{1'b0}}, i_push} - {{PTR_W{1'b0}}, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    assign o_item  = r_mem[r_rd];
    assign o_full  = (r_cnt == (PTR_W+1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
endmodule

// ----- rtl/scp_div.sv -----
`timescale 1ns / 1ps
module scp_div #(
    parameter int LANES = 1,
    parameter int NUM_W = 8,
    parameter int DEN_W = 8,
    parameter int TAG_W = 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [LANES-1:0][NUM_W-1:0]  i_num,
    input  logic [LANES-1:0][DEN_W-1:0]  i_den,
    input  logic [TAG_W-1:0]             i_tag,
    output logic                         o_valid,
    output logic [LANES-1:0][NUM_W-1:0]  o_quo,
    output logic [TAG_W-1:0]             o_tag
);
    logic                        r_v [0:NUM_W];
    logic [LANES-1:0][NUM_W-1:0] r_x [0:NUM_W];
    logic [LANES-1:0][DEN_W-1:0] r_d [0:NUM_W];
    logic [LANES-1:0][DEN_W-1:0] r_r [0:NUM_W];
    logic [TAG_W-1:0]            r_t [0:NUM_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= i_num;
            r_d[0] <= i_den;
            r_r[0] <= '0;
            r_t[0] <= i_tag;
        end
    end

    for (genvar gs = 0; gs < NUM_W; gs++) begin : g_stage
        logic [LANES-1:0][DEN_W-1:0] w_rem;
        logic [LANES-1:0][NUM_W-1:0] w_xn;

        for (genvar gl = 0; gl < LANES; gl++) begin : g_lane
            logic [DEN_W:0] w_sh;
            logic [DEN_W:0] w_diff;
            logic           w_ge;
            assign w_sh   = {r_r[gs][gl], r_x[gs][gl][NUM_W-1]};
            assign w_diff = w_sh - {1'b0, r_d[gs][gl]};
            assign w_ge   = (w_sh >= {1'b0, r_d[gs][gl]});
            assign w_rem[gl] = w_ge ? w_diff[DEN_W-1:0] : w_sh[DEN_W-1:0];
            assign w_xn[gl]  = {r_x[gs][gl][NUM_W-2:0], w_ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[gs+1] <= 1'b0;
            end else if (i_en) begin
                r_v[gs+1] <= r_v[gs];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[gs+1] <= w_xn;
                r_d[gs+1] <= r_d[gs];
                r_r[gs+1] <= w_rem;
                r_t[gs+1] <= r_t[gs];
            end
        end
    end

    assign o_valid = r_v[NUM_W];
    assign o_quo   = r_x[NUM_W];
    assign o_tag   = r_t[NUM_W];
endmodule

// ----- rtl/scp_front.sv -----
`timescale 1ns / 1ps
module scp_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  scp_pkg::t_cfg              i_cfg,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [scp_pkg::POS_W-1:0]  i_sprite_x,
    input  logic [scp_pkg::POS_W-1:0]  i_sprite_y,
    input  logic [scp_pkg::POS_W-1:0]  i_depth,
    input  logic [scp_pkg::COL_W-1:0]  i_column,
    output logic                       o_push,
    output scp_pkg::t_item             o_item,
    input  logic                       i_full
);
    import scp_pkg::*;

    logic w_en;

    logic                     r1_v;
    logic signed [DIFF_W-1:0] r1_dx, r1_dy;
    logic [POS_W-1:0]         r1_dep;
    logic [COL_W-1:0]         r1_col;

    logic                     r2_v;
    logic signed [PROD_W-1:0] r2_ta, r2_tb, r2_ya, r2_yb;
    logic signed [DETP_W-1:0] r2_da, r2_db;
    logic [POS_W-1:0]         r2_dep;
    logic [COL_W-1:0]         r2_col;

    logic                     r3_v;
    logic signed [TN_W-1:0]   r3_tn, r3_yn;
    logic signed [DET_W-1:0]  r3_det;
    logic [POS_W-1:0]         r3_dep;
    logic [COL_W-1:0]         r3_col;

    logic                     r4_v;
    logic signed [S_W-1:0]    r4_s;
    logic                     r4_yneg;
    logic [YMAG_W-1:0]        r4_ymag;
    logic [DMAG_W-1:0]        r4_dmag;
    logic [POS_W-1:0]         r4_dep;
    logic [COL_W-1:0]         r4_col;
    logic                     r4_fault;

    logic                     r5_v;
    t_item                    r5_item;

    logic [TN_W-1:0]  w_yabs;
    logic [DET_W-1:0] w_dabs;
    logic [S_W-1:0]   w_sabs;

    assign w_en    = ~(r5_v & i_full);
    assign o_ready = w_en;
    assign o_push  = r5_v & ~i_full;
    assign o_item  = r5_item;

    assign w_yabs = r3_yn[TN_W-1] ? -r3_yn : r3_yn;
    assign w_dabs = r3_det[DET_W-1] ? -r3_det : r3_det;
    assign w_sabs = r4_s[S_W-1] ? -r4_s : r4_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_dx  <= {1'b0, i_sprite_x} - {1'b0, i_cfg.eye_x};
            r1_dy  <= {1'b0, i_sprite_y} - {1'b0, i_cfg.eye_y};
            r1_dep <= i_depth;
            r1_col <= i_column;

            r2_ta  <= $signed(i_cfg.dir_y) * r1_dx;
            r2_tb  <= $signed(i_cfg.dir_x) * r1_dy;
            r2_ya  <= $signed(i_cfg.plane_x) * r1_dy;
            r2_yb  <= $signed(i_cfg.plane_y) * r1_dx;
            r2_da  <= $signed(i_cfg.plane_x) * $signed(i_cfg.dir_y);
            r2_db  <= $signed(i_cfg.dir_x) * $signed(i_cfg.plane_y);
            r2_dep <= r1_dep;
            r2_col <= r1_col;

            r3_tn  <= r2_ta - r2_tb;
            r3_yn  <= r2_ya - r2_yb;
            r3_det <= r2_da - r2_db;
            r3_dep <= r2_dep;
            r3_col <= r2_col;

            r4_s     <= r3_tn + r3_yn;
            r4_yneg  <= r3_yn[TN_W-1];
            r4_ymag  <= w_yabs[YMAG_W-1:0];
            r4_dmag  <= w_dabs[DMAG_W-1:0];
            r4_dep   <= r3_dep;
            r4_col   <= r3_col;
            r4_fault <= (r3_det == '0) | (r3_yn == '0) | (r3_dep == '0);

            r5_item.s_mag   <= w_sabs[SMAG_W-1:0];
            r5_item.neg     <= r4_s[S_W-1] ^ r4_yneg;
            r5_item.yn_mag  <= r4_ymag;
            r5_item.det_mag <= r4_dmag;
            r5_item.dep     <= r4_dep;
            r5_item.col     <= r4_col;
            r5_item.fault   <= r4_fault;
        end
    end
endmodule

// ----- rtl/scp_back.sv -----
`timescale 1ns / 1ps
module scp_back #(
    parameter int SCREEN_HEIGHT = 480,
    parameter int FRAC_BITS     = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  scp_pkg::t_cfg              i_cfg,
    input  scp_pkg::t_item             i_item,
    input  logic                       i_empty,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [scp_pkg::CTR_W-1:0]  o_screen_center,
    output logic [scp_pkg::ROW_W-1:0]  o_top_row,
    output logic [scp_pkg::ROW_W-1:0]  o_bottom_row,
    output logic [scp_pkg::TW_W-1:0]   o_texture_column,
    output logic                       o_fault
);
    import scp_pkg::*;

    localparam int H_W     = $clog2(SCREEN_HEIGHT + 1);
    localparam int HALF_H  = SCREEN_HEIGHT / 2;
    localparam int SW_W    = H_W + FRAC_BITS;
    localparam int N1_W    = HALF_W + SMAG_W;
    localparam int N2_W    = H_W + DMAG_W;
    localparam int NA_W    = (N1_W > N2_W) ? ((N1_W > SW_W) ? N1_W : SW_W)
                                           : ((N2_W > SW_W) ? N2_W : SW_W);
    localparam int TNUM_W  = ((SW_W > CEN_W) ? SW_W : CEN_W) + 2;
    localparam int PT_W    = TNUM_W + TW_W + 1;
    localparam int NB_W    = PT_W - 1;
    localparam int LANES_A = 3;
    localparam logic [NA_W-1:0] CEN_LIM = NA_W'(1) << CEN_SH;

    logic w_en;

    t_item r1_item;
    logic  r1_v;

    logic [LANES_A-1:0][NA_W-1:0]   w_num_a;
    logic [LANES_A-1:0][YMAG_W-1:0] w_den_a;
    logic [HALF_W-1:0]              w_half;
    t_tag_a                         w_tag_ai, w_tag_ao;
    logic                           w_va;
    logic [LANES_A-1:0][NA_W-1:0]   w_qa;

    logic [NA_W-1:0]  w_m;
    logic [CEN_W-1:0] w_cen;
    logic [NA_W-2:0]  w_lh2;
    logic [SW_W-1:0]  w_sw;

    logic             r3_v;
    logic [CEN_W-1:0] r3_centre;
    logic [ROW_W-1:0] r3_top, r3_bot;
    logic [SW_W-1:0]  r3_sw;
    logic             r3_fault;
    logic [COL_W-1:0] r3_col;

    logic [CTR_W-1:0] w_sat;

    logic              r4_v;
    logic [TNUM_W-1:0] r4_tnum;
    logic [CTR_W-1:0]  r4_sat;
    logic [ROW_W-1:0]  r4_top, r4_bot;
    logic [SW_W-1:0]   r4_sw;
    logic              r4_fault;

    logic                   r5_v;
    logic signed [PT_W-1:0] r5_prod;
    logic [CTR_W-1:0]       r5_sat;
    logic [ROW_W-1:0]       r5_top, r5_bot;
    logic [SW_W-1:0]        r5_sw;
    logic                   r5_fault;

    logic [PT_W-1:0] w_pabs;
    t_tag_b          w_tag_bi, w_tag_bo;
    logic            w_vb;
    logic [NB_W-1:0] w_qb;
    logic [TW_W-1:0] w_tex;

    logic             r_o_v;
    logic [CTR_W-1:0] r_o_centre;
    logic [ROW_W-1:0] r_o_top, r_o_bot;
    logic [TW_W-1:0]  r_o_tex;
    logic             r_o_fault;

    assign w_en  = ~r_o_v | i_ready;
    assign o_pop = w_en & ~i_empty;

    assign w_half     = i_cfg.screen_width[SWID_W-1:1];
    assign w_num_a[0] = NA_W'(w_half) * NA_W'(r1_item.s_mag);
    assign w_num_a[1] = NA_W'(SCREEN_HEIGHT) * NA_W'(r1_item.det_mag);
    assign w_num_a[2] = NA_W'(SCREEN_HEIGHT) << FRAC_BITS;
    assign w_den_a[0] = r1_item.yn_mag;
    assign w_den_a[1] = r1_item.yn_mag;
    assign w_den_a[2] = YMAG_W'(r1_item.dep);
    assign w_tag_ai   = '{col: r1_item.col, neg: r1_item.neg, fault: r1_item.fault};

    scp_div #(
        .LANES (LANES_A),
        .NUM_W (NA_W),
        .DEN_W (YMAG_W),
        .TAG_W ($bits(t_tag_a))
    ) u_div_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r1_v),
        .i_num   (w_num_a),
        .i_den   (w_den_a),
        .i_tag   (w_tag_ai),
        .o_valid (w_va),
        .o_quo   (w_qa),
        .o_tag   (w_tag_ao)
    );

    assign w_m   = (w_qa[0] > CEN_LIM) ? CEN_LIM : w_qa[0];
    assign w_cen = w_tag_ao.neg ? -{1'b0, w_m[CEN_W-2:0]} : {1'b0, w_m[CEN_W-2:0]};
    assign w_lh2 = w_qa[1][NA_W-1:1];
    assign w_sw  = w_qa[2][SW_W-1:0];

    always_comb begin
        if (!r3_centre[CEN_W-1] && (|r3_centre[CEN_W-2:CTR_W-1])) begin
            w_sat = {1'b0, {(CTR_W-1){1'b1}}};
        end else if (r3_centre[CEN_W-1] && !(&r3_centre[CEN_W-2:CTR_W-1])) begin
            w_sat = {1'b1, {(CTR_W-1){1'b0}}};
        end else begin
            w_sat = r3_centre[CTR_W-1:0];
        end
    end

    assign w_pabs   = r5_prod[PT_W-1] ? -r5_prod : r5_prod;
    assign w_tag_bi = '{centre: r5_sat, top: r5_top, bot: r5_bot,
                        fault: r5_fault, neg: r5_prod[PT_W-1]};

    scp_div #(
        .LANES (1),
        .NUM_W (NB_W),
        .DEN_W (SW_W),
        .TAG_W ($bits(t_tag_b))
    ) u_div_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r5_v),
        .i_num   (w_pabs[NB_W-1:0]),
        .i_den   (r5_sw),
        .i_tag   (w_tag_bi),
        .o_valid (w_vb),
        .o_quo   (w_qb),
        .o_tag   (w_tag_bo)
    );

    always_comb begin
        if (w_tag_bo.neg) begin
            w_tex = '0;
        end else if (w_qb > NB_W'(i_cfg.texture_width)) begin
            w_tex = i_cfg.texture_width;
        end else begin
            w_tex = w_qb[TW_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v  <= 1'b0;
            r3_v  <= 1'b0;
            r4_v  <= 1'b0;
            r5_v  <= 1'b0;
            r_o_v <= 1'b0;
        end else if (w_en) begin
            r1_v  <= ~i_empty;
            r3_v  <= w_va;
            r4_v  <= r3_v;
            r5_v  <= r4_v;
            r_o_v <= w_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_item <= i_item;

            r3_centre <= w_cen;
            r3_top    <= (w_lh2 >= (NA_W-1)'(HALF_H)) ? '0
                         : ROW_W'(HALF_H) - w_lh2[ROW_W-1:0];
            r3_bot    <= (w_lh2 >= (NA_W-1)'(SCREEN_HEIGHT - HALF_H))
                         ? ROW_W'(SCREEN_HEIGHT - 1)
                         : ROW_W'(HALF_H) + w_lh2[ROW_W-1:0];
            r3_sw     <= w_sw;
            r3_fault  <= w_tag_ao.fault | (w_sw == '0);
            r3_col    <= w_tag_ao.col;

            r4_tnum  <= {{(TNUM_W-COL_W){1'b0}}, r3_col}
                      + {{(TNUM_W-SW_W+1){1'b0}}, r3_sw[SW_W-1:1]}
                      - {{(TNUM_W-CEN_W){r3_centre[CEN_W-1]}}, r3_centre};
            r4_sat   <= w_sat;
            r4_top   <= r3_top;
            r4_bot   <= r3_bot;
            r4_sw    <= r3_sw;
            r4_fault <= r3_fault;

            r5_prod  <= $signed(r4_tnum) * $signed({1'b0, i_cfg.texture_width});
            r5_sat   <= r4_sat;
            r5_top   <= r4_top;
            r5_bot   <= r4_bot;
            r5_sw    <= r4_sw;
            r5_fault <= r4_fault;

            r_o_fault  <= w_tag_bo.fault;
            r_o_centre <= w_tag_bo.fault ? '0 : w_tag_bo.centre;
            r_o_top    <= w_tag_bo.fault ? '0 : w_tag_bo.top;
            r_o_bot    <= w_tag_bo.fault ? '0 : w_tag_bo.bot;
            r_o_tex    <= w_tag_bo.fault ? '0 : w_tex;
        end
    end

    assign o_valid          = r_o_v;
    assign o_screen_center  = r_o_centre;
    assign o_top_row        = r_o_top;
    assign o_bottom_row     = r_o_bot;
    assign o_texture_column = r_o_tex;
    assign o_fault          = r_o_fault;
endmodule

// ----- rtl/sprite_column_projection.sv -----
`timescale 1ns / 1ps
// Sprite column projection: takes one request per clock while o_ready is high (it drops
// while the queue is full) and returns one result per request, in order. A request passes
// the front pipeline, the queue, then the back end, whose two pipelined restoring dividers
// have quotient widths NA (55 at the defaults) and NB (57 at the defaults), one quotient
// bit per stage. The long latency comes from those divider chains; a four-entry queue
// between front and back lets the input keep flowing while a result waits to be taken.
// Configuration writes are accepted on every cycle and must only happen while idle.
module sprite_column_projection #(
    parameter int SCREEN_HEIGHT = 480,
    parameter int FRAC_BITS     = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [2:0]                 i_cfg_index,
    input  logic [scp_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [scp_pkg::POS_W-1:0]  i_sprite_x,
    input  logic [scp_pkg::POS_W-1:0]  i_sprite_y,
    input  logic [scp_pkg::POS_W-1:0]  i_depth,
    input  logic [scp_pkg::COL_W-1:0]  i_column,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [scp_pkg::CTR_W-1:0]  o_screen_center,
    output logic [scp_pkg::ROW_W-1:0]  o_top_row,
    output logic [scp_pkg::ROW_W-1:0]  o_bottom_row,
    output logic [scp_pkg::TW_W-1:0]   o_texture_column,
    output logic                       o_fault
);
    import scp_pkg::*;

    t_cfg  r_cfg;
    logic  w_push, w_full, w_pop, w_empty;
    t_item w_fi, w_fo;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.eye_x         <= '0;
            r_cfg.eye_y         <= '0;
            r_cfg.dir_x         <= VEC_W'(65536);
            r_cfg.dir_y         <= '0;
            r_cfg.plane_x       <= '0;
            r_cfg.plane_y       <= VEC_W'(43254);
            r_cfg.screen_width  <= SWID_W'(640);
            r_cfg.texture_width <= TW_W'(64);
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_EYE_X:         r_cfg.eye_x         <= i_cfg_data[POS_W-1:0];
                REG_EYE_Y:         r_cfg.eye_y         <= i_cfg_data[POS_W-1:0];
                REG_VIEW_DIR_X:    r_cfg.dir_x         <= i_cfg_data[VEC_W-1:0];
                REG_VIEW_DIR_Y:    r_cfg.dir_y         <= i_cfg_data[VEC_W-1:0];
                REG_PLANE_X:       r_cfg.plane_x       <= i_cfg_data[VEC_W-1:0];
                REG_PLANE_Y:       r_cfg.plane_y       <= i_cfg_data[VEC_W-1:0];
                REG_SCREEN_WIDTH:  r_cfg.screen_width  <= i_cfg_data[SWID_W-1:0];
                REG_TEXTURE_WIDTH: r_cfg.texture_width <= i_cfg_data[TW_W-1:0];
                default:           r_cfg               <= r_cfg;
            endcase
        end
    end

    scp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_sprite_x (i_sprite_x),
        .i_sprite_y (i_sprite_y),
        .i_depth    (i_depth),
        .i_column   (i_column),
        .o_push     (w_push),
        .o_item     (w_fi),
        .i_full     (w_full)
    );

    scp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_fi),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_item  (w_fo),
        .o_empty (w_empty)
    );

    scp_back #(
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .FRAC_BITS     (FRAC_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_item           (w_fo),
        .i_empty          (w_empty),
        .o_pop            (w_pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_screen_center  (o_screen_center),
        .o_top_row        (o_top_row),
        .o_bottom_row     (o_bottom_row),
        .o_texture_column (o_texture_column),
        .o_fault          (o_fault)
    );

    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_fault |-> o_screen_center == '0 && o_top_row == '0
                               && o_bottom_row == '0 && o_texture_column == '0)
        else $error("faulted result carries non-zero fields");

    a_tex_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_texture_column <= r_cfg.texture_width)
        else $error("texture column beyond texture width");

    a_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_bottom_row <= ROW_W'(SCREEN_HEIGHT - 1)
                    && o_top_row <= ROW_W'(SCREEN_HEIGHT / 2))
        else $error("stripe rows out of range");
endmodule
